>>> hdl/hsp_pkg.sv
// Shared constants, types and the arctangent table for the heading smoother.
package hsp_pkg;

  localparam int HORIZON_MAX     = 32;
  localparam int ROBOT_COUNT     = 8;
  localparam int ATAN_ITERATIONS = 24;
  localparam int IDX_W           = $clog2(HORIZON_MAX);
  localparam int CNT_W           = $clog2(HORIZON_MAX + 1);

  localparam logic signed [31:0] PI_Q      = 32'sd52707179;
  localparam logic signed [31:0] HALF_PI_Q = 32'sd26353589;
  localparam logic [35:0]        TWO_PI_Q  = 36'd105414357;

  localparam logic [2:0] REG_MODE     = 3'd0;
  localparam logic [2:0] REG_SPEED    = 3'd1;
  localparam logic [2:0] REG_DIST     = 3'd2;
  localparam logic [2:0] REG_GAIN     = 3'd3;
  localparam logic [2:0] REG_LOOK     = 3'd4;
  localparam logic [2:0] REG_CAP_EN   = 3'd5;
  localparam logic [2:0] REG_MAX_STEP = 3'd6;
  localparam logic [2:0] REG_SEND     = 3'd7;

  typedef struct packed {
    logic               done;
    logic signed [31:0] angle;
  } hsp_cordic_res_t;

  function automatic logic signed [31:0] atan_entry(input logic [4:0] i);
    logic signed [31:0] r;
    case (i)
      5'd0:  r = 32'sd13176795;
      5'd1:  r = 32'sd7778716;
      5'd2:  r = 32'sd4110060;
      5'd3:  r = 32'sd2086331;
      5'd4:  r = 32'sd1047214;
      5'd5:  r = 32'sd524117;
      5'd6:  r = 32'sd262123;
      5'd7:  r = 32'sd131069;
      5'd8:  r = 32'sd65536;
      5'd9:  r = 32'sd32768;
      5'd10: r = 32'sd16384;
      5'd11: r = 32'sd8192;
      5'd12: r = 32'sd4096;
      5'd13: r = 32'sd2048;
      5'd14: r = 32'sd1024;
      5'd15: r = 32'sd512;
      5'd16: r = 32'sd256;
      5'd17: r = 32'sd128;
      5'd18: r = 32'sd64;
      5'd19: r = 32'sd32;
      5'd20: r = 32'sd16;
      5'd21: r = 32'sd8;
      5'd22: r = 32'sd4;
      5'd23: r = 32'sd2;
      5'd24: r = 32'sd1;
      default: r = 32'sd0;
    endcase
    return r;
  endfunction

endpackage

>>> hdl/heading_smoother_per_robot_top.sv
// Top level of the per-robot heading smoother: point store, sequencer and registers.
//
// Input channel (in_valid/in_stall): one planned point per transaction. Points
// are stored until final_point is set, or the store holds HORIZON_MAX points.
// The robot field of the first point selects the seed heading.
// Output channel (out_valid/out_stall): one heading per transaction, step_index
// counting from 0, end_of_run on the last one sent; send_count caps the headings sent.
// After the final point in_stall stays high until the last heading is taken.
// Each heading, when the CORDIC runs, takes the store reads, 4 multiplier passes,
// 24 CORDIC iterations, 7 wrap steps and the accumulate; when the heading holds
// the CORDIC is skipped. The multiplier is shared by all passes and the CORDIC
// does one iteration per cycle.
// A stalled receiver holds the sequencer in its output state; nothing is lost.
// Reset (rst, synchronous) clears the seeds to zero, the point count, and
// restores register defaults. The point store needs no clearing.
// Registers sit on an APB port at byte address 4*index; pready is always high.
module heading_smoother_per_robot_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         robot,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] vel_x,
  input  logic signed [31:0] vel_y,
  input  logic               final_point,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [4:0]         step_index,
  output logic signed [31:0] heading,
  output logic               end_of_run,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import hsp_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RK   = 4'd1;
  localparam logic [3:0] S_RJ   = 4'd2;
  localparam logic [3:0] S_DIF  = 4'd3;
  localparam logic [3:0] S_M1   = 4'd4;
  localparam logic [3:0] S_M2   = 4'd5;
  localparam logic [3:0] S_M3   = 4'd6;
  localparam logic [3:0] S_CMP  = 4'd7;
  localparam logic [3:0] S_CORD = 4'd8;
  localparam logic [3:0] S_WRAP = 4'd9;
  localparam logic [3:0] S_MOD  = 4'd10;
  localparam logic [3:0] S_FIX  = 4'd11;
  localparam logic [3:0] S_GM   = 4'd12;
  localparam logic [3:0] S_GP   = 4'd13;
  localparam logic [3:0] S_ACC  = 4'd14;
  localparam logic [3:0] S_OUT  = 4'd15;

  // configuration
  logic        mode;
  logic [31:0] speed_freeze;
  logic [31:0] distance_hold;
  logic [16:0] ema_gain;
  logic [4:0]  lookahead;
  logic        cap_enable;
  logic [30:0] max_step;
  logic [5:0]  send_count;

  logic [3:0]             state;
  logic [CNT_W-1:0]       pc;
  logic [CNT_W-1:0]       pc_next;
  logic [CNT_W-1:0]       n;
  logic [CNT_W-1:0]       ns;
  logic [CNT_W-1:0]       sc;
  logic [IDX_W-1:0]       k;
  logic [IDX_W-1:0]       j;
  logic [CNT_W:0]         jj;
  logic [IDX_W-1:0]       raddr;
  logic [2:0]             cur_robot;
  logic signed [31:0]     seed [ROBOT_COUNT];
  logic [127:0]           mem [HORIZON_MAX];
  logic [127:0]           rdata;
  logic [127:0]           kent;
  logic signed [32:0]     vecx;
  logic signed [32:0]     vecy;
  logic signed [32:0]     dx;
  logic signed [32:0]     dy;
  logic [32:0]            absx;
  logic [32:0]            absy;
  logic [64:0]            sum;
  logic                   below;
  logic signed [31:0]     prev;
  logic signed [31:0]     raw;
  logic                   vneg;
  logic [35:0]            r;
  logic [2:0]             s;
  logic [35:0]            sub_val;
  logic [35:0]            rr;
  logic signed [35:0]     w;
  logic                   wneg;
  logic [26:0]            wmag;
  logic signed [28:0]     stepv;
  logic signed [44:0]     sp;
  logic signed [44:0]     spr;
  logic signed [32:0]     capped;
  logic signed [32:0]     ms;
  logic signed [33:0]     acc;
  logic signed [31:0]     acc_sat;
  logic signed [34:0]     v;
  logic [31:0]            ma;
  logic [31:0]            mb;
  logic [63:0]            mp;
  logic [31:0]            thr;
  logic                   cord_start;
  hsp_cordic_res_t        cres;

  assign pready   = 1'b1;
  assign in_stall = (state != S_IDLE);

  hsp_mult u_mult (.clk(clk), .a(ma), .b(mb), .p(mp));

  hsp_cordic u_cordic (
    .clk(clk), .rst(rst), .start(cord_start), .xin(vecx), .yin(vecy), .res(cres)
  );

  // registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= 1'b0;
      speed_freeze  <= '0;
      distance_hold <= '0;
      ema_gain      <= 17'd65536;
      lookahead     <= 5'd1;
      cap_enable    <= 1'b0;
      max_step      <= '0;
      send_count    <= 6'd32;
    end else if (psel && penable && pwrite) begin
      case (paddr[4:2])
        REG_MODE:     mode          <= pwdata[0];
        REG_SPEED:    speed_freeze  <= pwdata;
        REG_DIST:     distance_hold <= pwdata;
        REG_GAIN:     ema_gain      <= pwdata[16:0];
        REG_LOOK:     lookahead     <= pwdata[4:0];
        REG_CAP_EN:   cap_enable    <= pwdata[0];
        REG_MAX_STEP: max_step      <= pwdata[30:0];
        REG_SEND:     send_count    <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_MODE:     prdata = {31'd0, mode};
      REG_SPEED:    prdata = speed_freeze;
      REG_DIST:     prdata = distance_hold;
      REG_GAIN:     prdata = {15'd0, ema_gain};
      REG_LOOK:     prdata = {27'd0, lookahead};
      REG_CAP_EN:   prdata = {31'd0, cap_enable};
      REG_MAX_STEP: prdata = {1'b0, max_step};
      REG_SEND:     prdata = {26'd0, send_count};
      default:      prdata = '0;
    endcase
  end

  // point store
  assign jj    = (CNT_W + 1)'(k) + (CNT_W + 1)'(lookahead);
  assign j     = (jj > (CNT_W + 1)'(n - 1'b1)) ? IDX_W'(n - 1'b1) : jj[IDX_W-1:0];
  assign raddr = (state == S_RK) ? k : j;

  always_ff @(posedge clk) begin
    if (in_valid && state == S_IDLE) begin
      mem[pc[IDX_W-1:0]] <= {pos_x, pos_y, vel_x, vel_y};
    end
    rdata <= mem[raddr];
  end

  // datapath selects
  assign pc_next = pc + 1'b1;
  assign sc      = (send_count == '0) ? CNT_W'(1) : CNT_W'(send_count);
  assign dx      = {rdata[127], rdata[127:96]} - {kent[127], kent[127:96]};
  assign dy      = {rdata[95], rdata[95:64]} - {kent[95], kent[95:64]};
  assign absx    = vecx[32] ? 33'(-vecx) : 33'(vecx);
  assign absy    = vecy[32] ? 33'(-vecy) : 33'(vecy);
  assign thr     = mode ? speed_freeze : distance_hold;
  assign below   = sum < {1'b0, mp};
  assign cord_start = (state == S_CMP) && !below;

  always_comb begin
    case (state)
      S_M1:    begin ma = absx[31:0]; mb = absx[31:0]; end
      S_M2:    begin ma = absy[31:0]; mb = absy[31:0]; end
      S_M3:    begin ma = thr;        mb = thr;        end
      S_GM:    begin ma = {15'd0, ema_gain}; mb = {5'd0, wmag}; end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  assign v       = 35'(raw) - 35'(prev) + 35'(PI_Q);
  assign sub_val = TWO_PI_Q << s;
  assign rr      = (vneg && r != '0) ? (TWO_PI_Q - r) : r;
  assign w       = $signed(rr) - 36'(PI_Q);
  assign sp      = wneg ? -$signed({1'b0, mp[43:0]}) : $signed({1'b0, mp[43:0]});
  assign spr     = sp + 45'sd32768;
  assign ms      = $signed({2'b00, max_step});

  always_comb begin
    capped = 33'(stepv);
    if (!mode && cap_enable) begin
      if (capped > ms) capped = ms;
      if (capped < -ms) capped = -ms;
    end
  end

  assign acc = 34'(prev) + 34'(capped);

  always_comb begin
    if (acc > 34'sd2147483647) acc_sat = 32'sh7FFFFFFF;
    else if (acc < -34'sd2147483648) acc_sat = 32'sh80000000;
    else acc_sat = acc[31:0];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pc        <= '0;
      cur_robot <= '0;
      out_valid <= 1'b0;
      for (int q = 0; q < ROBOT_COUNT; q++) seed[q] <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (pc == '0) cur_robot <= robot;
            if (final_point || pc_next == CNT_W'(HORIZON_MAX)) begin
              n     <= pc_next;
              ns    <= (sc > pc_next) ? pc_next : sc;
              k     <= '0;
              prev  <= seed[(pc == '0) ? robot : cur_robot];
              pc    <= '0;
              state <= S_RK;
            end else begin
              pc <= pc_next;
            end
          end
        end
        S_RK: state <= S_RJ;
        S_RJ: begin
          kent  <= rdata;
          state <= S_DIF;
        end
        S_DIF: begin
          if (mode) begin
            vecx <= {kent[63], kent[63:32]};
            vecy <= {kent[31], kent[31:0]};
          end else begin
            vecx <= dx;
            vecy <= dy;
          end
          state <= S_M1;
        end
        S_M1: state <= S_M2;
        S_M2: begin
          sum   <= {1'b0, mp};
          state <= S_M3;
        end
        S_M3: begin
          sum   <= sum + {1'b0, mp};
          state <= S_CMP;
        end
        S_CMP: begin
          // hold the heading when the vector is too short
          if (below) begin
            raw   <= prev;
            state <= S_WRAP;
          end else begin
            state <= S_CORD;
          end
        end
        S_CORD: begin
          if (cres.done) begin
            raw   <= cres.angle;
            state <= S_WRAP;
          end
        end
        S_WRAP: begin
          vneg  <= v[34];
          r     <= v[34] ? 36'(-v) : 36'(v);
          s     <= 3'd6;
          state <= S_MOD;
        end
        S_MOD: begin
          if (r >= sub_val) r <= r - sub_val;
          s <= s - 3'd1;
          if (s == 3'd0) state <= S_FIX;
        end
        S_FIX: begin
          wneg  <= w[35];
          wmag  <= w[35] ? 27'(-w) : w[26:0];
          state <= S_GM;
        end
        S_GM: state <= S_GP;
        S_GP: begin
          stepv <= spr[44:16];
          state <= S_ACC;
        end
        S_ACC: begin
          prev       <= acc_sat;
          heading    <= acc_sat;
          step_index <= 5'(k);
          end_of_run <= (CNT_W'(k) == ns - 1'b1);
          out_valid  <= 1'b1;
          state      <= S_OUT;
        end
        S_OUT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            if (end_of_run) begin
              seed[cur_robot] <= prev;
              state           <= S_IDLE;
            end else begin
              k     <= k + 1'b1;
              state <= S_RK;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_busy_while_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("input taken while a heading is pending");

  a_idle_after_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && end_of_run |=> !in_stall)
    else $error("block not idle after the last heading");

  a_index_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ({1'b0, step_index} < ns)) else $error("step index beyond send count");

endmodule

>>> hdl/hsp_mult.sv
// Shared 32x32 unsigned multiplier with a registered product.
module hsp_mult (
  input  logic        clk,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [63:0] p
);
  always_ff @(posedge clk) begin
    p <= 64'(a) * 64'(b);
  end
endmodule

>>> hdl/hsp_cordic.sv
// Iterative vectoring CORDIC atan2, one micro-rotation per cycle.
module hsp_cordic (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic signed [32:0]       xin,
  input  logic signed [32:0]       yin,
  output hsp_pkg::hsp_cordic_res_t res
);
  import hsp_pkg::*;

  logic               busy;
  logic [4:0]         i;
  logic signed [35:0] x;
  logic signed [35:0] y;
  logic signed [31:0] z;
  logic               done;
  logic signed [35:0] xe;
  logic signed [35:0] ye;
  logic signed [35:0] xs;
  logic signed [35:0] ys;

  assign xe = {{3{xin[32]}}, xin};
  assign ye = {{3{yin[32]}}, yin};
  assign xs = x >>> i;
  assign ys = y >>> i;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        i <= '0;
        if (xin == '0 && yin == '0) begin
          z    <= '0;
          done <= 1'b1;
        end else begin
          busy <= 1'b1;
          // pre-rotate the left half plane by a quarter turn
          if (xin[32] && !yin[32]) begin
            x <= ye;
            y <= -xe;
            z <= HALF_PI_Q;
          end else if (xin[32]) begin
            x <= -ye;
            y <= xe;
            z <= -HALF_PI_Q;
          end else begin
            x <= xe;
            y <= ye;
            z <= '0;
          end
        end
      end else if (busy) begin
        if (!y[35]) begin
          x <= x + ys;
          y <= y - xs;
          z <= z + atan_entry(i);
        end else begin
          x <= x - ys;
          y <= y + xs;
          z <= z - atan_entry(i);
        end
        i <= i + 5'd1;
        if (i == 5'(ATAN_ITERATIONS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign res.done  = done;
  assign res.angle = z;
endmodule

>>> dv/tb_heading_smoother_per_robot_top.sv
// Self-checking testbench for the per-robot heading smoother top level.
module tb_heading_smoother_per_robot_top;
  import hsp_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 2000;
  localparam int GAP_MAX        = 18;

  typedef struct {
    logic [4:0]         step;
    logic signed [31:0] hdg;
    logic               eor;
  } heading_exp_t;

  class heading_predictor;
    heading_exp_t expected_headings[$];
    longint       px[HORIZON_MAX], py[HORIZON_MAX], pvx[HORIZON_MAX], pvy[HORIZON_MAX];
    longint       seeds[ROBOT_COUNT];
    longint       atan_q[ATAN_ITERATIONS];
    int           npts;
    int           rob;
    int           fails;
    bit           c_mode, c_cap;
    longint       c_speed, c_dist, c_gain, c_look, c_max;
    int           c_send;

    function new();
      atan_q = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
                 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
                 256, 128, 64, 32, 16, 8, 4, 2};
      foreach (seeds[i]) seeds[i] = 0;
      npts = 0; rob = 0; fails = 0;
      c_mode = 0; c_speed = 0; c_dist = 0; c_gain = 65536; c_look = 1;
      c_cap = 0; c_max = 0; c_send = 32;
    endfunction

    function void set_reg(logic [2:0] r, logic [31:0] v);
      case (r)
        REG_MODE:     c_mode  = v[0];
        REG_SPEED:    c_speed = longint'(v);
        REG_DIST:     c_dist  = longint'(v);
        REG_GAIN:     c_gain  = longint'(v[16:0]);
        REG_LOOK:     c_look  = longint'(v[4:0]);
        REG_CAP_EN:   c_cap   = v[0];
        REG_MAX_STEP: c_max   = longint'(v[30:0]);
        REG_SEND:     c_send  = int'(v[5:0]);
        default: ;
      endcase
    endfunction

    function bit under(longint dx, longint dy, longint t);
      bit [63:0] a, b, tt;
      bit [64:0] sa, sb, sum;
      a = dx < 0 ? -dx : dx;
      b = dy < 0 ? -dy : dy;
      sa = a * a;
      sb = b * b;
      sum = sa + sb;
      tt = t;
      if (sum[64]) return 0;
      return sum[63:0] < tt * tt;
    endfunction

    function longint vec_angle(longint y, longint x);
      longint z, t, xs, ys;
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
        if (y >= 0) begin
          t = x; x = y; y = -t; z = HALF_PI_Q;
        end else begin
          t = x; x = -y; y = t; z = -HALF_PI_Q;
        end
      end
      for (int i = 0; i < ATAN_ITERATIONS; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y >= 0) begin
          x += ys; y -= xs; z += atan_q[i];
        end else begin
          x -= ys; y += xs; z -= atan_q[i];
        end
      end
      return z;
    endfunction

    function longint wrap_err(longint e);
      longint r, two;
      two = TWO_PI_Q;
      r = (e + PI_Q) % two;
      if (r < 0) r += two;
      return r - PI_Q;
    endfunction

    function void note_point(logic [2:0] r, logic signed [31:0] x, logic signed [31:0] y,
                             logic signed [31:0] vx, logic signed [31:0] vy, logic fin);
      int n, ns, j;
      longint prev, raw, stepv, dx, dy;
      heading_exp_t e;
      if (npts == 0) rob = int'(r) % ROBOT_COUNT;
      px[npts] = x; py[npts] = y; pvx[npts] = vx; pvy[npts] = vy;
      npts++;
      if (!fin && npts < HORIZON_MAX) return;
      n = npts;
      ns = c_send == 0 ? 1 : c_send;
      if (ns > n) ns = n;
      prev = seeds[rob];
      for (int k = 0; k < n; k++) begin
        if (!c_mode) begin
          j = (k + c_look > n - 1) ? n - 1 : k + int'(c_look);
          dx = px[j] - px[k];
          dy = py[j] - py[k];
          raw = under(dx, dy, c_dist) ? prev : vec_angle(dy, dx);
        end else begin
          raw = under(pvx[k], pvy[k], c_speed) ? prev : vec_angle(pvy[k], pvx[k]);
        end
        stepv = (c_gain * wrap_err(raw - prev) + 32768) >>> 16;
        if (!c_mode && c_cap) begin
          if (stepv > c_max) stepv = c_max;
          if (stepv < -c_max) stepv = -c_max;
        end
        prev = prev + stepv;
        if (prev > 64'sd2147483647) prev = 64'sd2147483647;
        if (prev < -64'sd2147483648) prev = -64'sd2147483648;
        if (k < ns) begin
          e.step = k[4:0];
          e.hdg  = prev[31:0];
          e.eor  = (k == ns - 1);
          expected_headings.push_back(e);
          if (k == ns - 1) seeds[rob] = prev;
        end
      end
      npts = 0;
    endfunction

    function void check_heading(logic [4:0] s, logic signed [31:0] h, logic eor);
      heading_exp_t e;
      if (expected_headings.size() == 0) begin
        $display("%0t: unexpected heading step %0d heading %0d", $time, s, h);
        fails++;
        return;
      end
      e = expected_headings.pop_front();
      if (s !== e.step) begin
        $display("%0t: step_index expected %0d actual %0d", $time, e.step, s);
        fails++;
      end
      if (h !== e.hdg) begin
        $display("%0t: heading expected %0d actual %0d", $time, e.hdg, h);
        fails++;
      end
      if (eor !== e.eor) begin
        $display("%0t: end_of_run expected %0b actual %0b", $time, e.eor, eor);
        fails++;
      end
    endfunction
  endclass

  logic               clk = 0;
  logic               rst;
  logic               in_valid, in_stall;
  logic [2:0]         robot;
  logic signed [31:0] pos_x, pos_y, vel_x, vel_y;
  logic               final_point;
  logic               out_valid, out_stall;
  logic [4:0]         step_index;
  logic signed [31:0] heading;
  logic               end_of_run;
  logic               psel, penable, pwrite;
  logic [4:0]         paddr;
  logic [31:0]        pwdata, prdata;
  logic               pready;

  heading_predictor pred = new();
  bit               quiet;
  int               idle_cycles;
  int               phase_items;

  heading_smoother_per_robot_top uut (.*);

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) pred.check_heading(step_index, heading, end_of_run);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Receiver: random stall before each transaction.
  initial begin
    int w;
    out_stall <= 1;
    @(negedge rst);
    forever begin
      w = quiet ? 0 : $urandom_range(0, GAP_MAX);
      if (w > 0) begin
        out_stall <= 1;
        repeat (w) @(posedge clk);
      end
      out_stall <= 0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Back-to-back writes keep psel high; configure drops it after the last one.
  task automatic write_reg(logic [2:0] r, logic [31:0] v);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {r, 2'b00}; pwdata <= v;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    pred.set_reg(r, v);
  endtask

  task automatic drain();
    while (pred.expected_headings.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure(logic m, logic [31:0] sp, logic [31:0] ds, logic [16:0] g,
                           logic [4:0] lk, logic ce, logic [30:0] ms, logic [5:0] sc);
    // drop the last transaction so it is not taken again once the block idles
    in_valid <= 0;
    drain();
    write_reg(REG_MODE, {31'd0, m});
    write_reg(REG_SPEED, sp);
    write_reg(REG_DIST, ds);
    write_reg(REG_GAIN, {15'd0, g});
    write_reg(REG_LOOK, {27'd0, lk});
    write_reg(REG_CAP_EN, {31'd0, ce});
    write_reg(REG_MAX_STEP, {1'b0, ms});
    write_reg(REG_SEND, {26'd0, sc});
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  task automatic send_point(logic [2:0] r, logic [31:0] x, logic [31:0] y,
                            logic [31:0] vx, logic [31:0] vy, logic fin);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, GAP_MAX);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    robot <= r; pos_x <= x; pos_y <= y; vel_x <= vx; vel_y <= vy; final_point <= fin;
    in_valid <= 1;
    do @(posedge clk); while (in_stall);
    pred.note_point(r, x, y, vx, vy, fin);
    phase_items++;
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 6))
      0, 1: return $urandom;
      2:    return $urandom_range(0, 8 * 65536) - 4 * 65536;
      3:    return 32'd0;
      4:    return 32'h7fffffff;
      5:    return 32'h80000000;
      default: return $urandom_range(0, 1 << 25) - (1 << 24);
    endcase
  endfunction

  task automatic random_horizon();
    int len;
    logic fin;
    logic [2:0] r;
    len = ($urandom_range(0, 14) == 0) ? HORIZON_MAX : $urandom_range(1, 8);
    r = 3'($urandom);
    for (int k = 0; k < len; k++) begin
      fin = (k == len - 1) ? ((len == HORIZON_MAX) ? logic'($urandom_range(0, 1)) : 1'b1)
                           : ($urandom_range(0, 19) == 0);
      send_point(k == 0 ? r : 3'($urandom), pick_value(), pick_value(),
                 pick_value(), pick_value(), fin);
    end
  endtask

  task automatic random_phase(int items);
    phase_items = 0;
    while (phase_items < items) random_horizon();
  endtask

  initial begin
    rst <= 1; in_valid <= 0; robot <= 0; pos_x <= 0; pos_y <= 0; vel_x <= 0; vel_y <= 0;
    final_point <= 0; psel <= 0; penable <= 0; pwrite <= 0; paddr <= 0; pwdata <= 0;
    idle_cycles <= 0;
    quiet = 0;
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    configure(1'b0, 32'd0, 32'd0, 17'd65536, 5'd1, 1'b0, 31'd0, 6'd32);
    // Directed: zero vector, extremes, left half plane, robot latch.
    send_point(3'd0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b1);
    send_point(3'd7, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h80000000, 1'b0);
    send_point(3'd2, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 1'b0);
    send_point(3'd3, 32'h00000000, 32'h7fffffff, 32'h00000000, 32'h00000000, 1'b0);
    send_point(3'd4, 32'hffff0000, 32'h00010000, 32'hffff0000, 32'hffff0000, 1'b0);
    send_point(3'd5, 32'hfffe0000, 32'hfffe0000, 32'h00010000, 32'h00010000, 1'b1);
    send_point(3'd7, 32'd0, 32'd0, 32'd0, 32'd0, 1'b1);
    configure(1'b1, 32'h00010000, 32'd0, 17'h1ffff, 5'd31, 1'b1, 31'd0, 6'd0);
    send_point(3'd1, 32'd0, 32'd0, 32'h00008000, 32'h00008000, 1'b0);
    send_point(3'd1, 32'd0, 32'd0, 32'h80000000, 32'h00000001, 1'b0);
    send_point(3'd1, 32'd0, 32'd0, 32'h80000000, 32'hffffffff, 1'b1);
    configure(1'b0, 32'hffffffff, 32'h00020000, 17'd40000, 5'd0, 1'b1, 31'd1000000, 6'd63);
    send_point(3'd6, 32'd0, 32'd0, 32'd1, 32'd1, 1'b0);
    send_point(3'd6, 32'h00100000, 32'h00100000, 32'd1, 32'd1, 1'b0);
    send_point(3'd6, 32'h80000000, 32'h00100000, 32'd1, 32'd1, 1'b1);

    configure(1'b0, 32'd0, 32'h00010000, 17'd65536, 5'd1, 1'b1, 31'd2000000, 6'd32);
    random_phase(40);
    configure(1'b1, 32'h00040000, 32'd0, 17'd32768, 5'd3, 1'b1, 31'd0, 6'd3);
    quiet = 1;
    random_phase(60);
    quiet = 0;
    configure(1'b0, 32'hffffffff, 32'hffffffff, 17'd0, 5'd31, 1'b0, 31'h7fffffff, 6'd1);
    random_phase(40);
    configure(1'b0, 32'd0, 32'd0, 17'h1ffff, 5'd0, 1'b1, 31'd0, 6'd0);
    random_phase(40);
    for (int p = 0; p < 4; p++) begin
      configure(1'($urandom), $urandom_range(0, 1) ? $urandom : $urandom_range(0, 1 << 20),
                $urandom_range(0, 1) ? $urandom : $urandom_range(0, 1 << 20),
                17'($urandom_range(0, 131071)), 5'($urandom), 1'($urandom),
                31'($urandom), 6'($urandom));
      random_phase(60);
    end
    in_valid <= 0;
    drain();
    if (pred.fails == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
